>>> rtl/mstl_pkg.sv
// ----------------------------------------------------------------------------
// mstl_pkg
// shared types and fixed widths of the spanning tree length unit
// ----------------------------------------------------------------------------
package mstl_pkg;

  // total length field, fixed point with the fraction bits in the low bits
  localparam int SUM_BITS   = 34;
  localparam int OUT_TDATA_W = ((SUM_BITS + 7) / 8) * 8;

  // status of the iterative root unit
  typedef struct packed {
    logic busy;
    logic done;
  } mstl_sqrt_stat_t;

endpackage

>>> rtl/mstl_ram.sv
// ----------------------------------------------------------------------------
// mstl_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module mstl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mstl_sqrt.sv
// ----------------------------------------------------------------------------
// mstl_sqrt
// iterative fixed point root, floor(sqrt(v << 2*frac)), two operand bits a cycle
// ----------------------------------------------------------------------------
module mstl_sqrt
  import mstl_pkg::*;
#(
  parameter int IN_W      = 25,
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [IN_W-1:0]                      value,
  output logic [(IN_W + 1) / 2 + FRAC_BITS-1:0] root,
  output mstl_sqrt_stat_t                      stat
);

  localparam int P  = (IN_W + 1) / 2 + FRAC_BITS;
  localparam int SW = $clog2(P + 1);

  logic [2*P-1:0] op;
  logic [P+1:0]   rem;
  logic [P+1:0]   rem_sh;
  logic [P+1:0]   trial;
  logic [SW-1:0]  steps;

  assign rem_sh = {rem[P-1:0], op[2*P-1:2*P-2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat  <= '0;
      steps <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        steps     <= SW'(P);
        op        <= {{(2*P-IN_W){1'b0}}, value} << (2 * FRAC_BITS);
        rem       <= '0;
        root      <= '0;
      end else if (stat.busy) begin
        op <= op << 2;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[P-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[P-2:0], 1'b0};
        end
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/euclidean_mst_length_unit.sv
// ----------------------------------------------------------------------------
// euclidean_mst_length_unit
// euclidean minimum spanning tree length over a set of streamed points
// ----------------------------------------------------------------------------
// usage
//   slave side: one point per beat, x in the low bits, y above, tlast marks
//   the final point of a set. points are stored at one per cycle. points
//   beyond MAX_POINTS are dropped and flagged.
//   after the last beat s_tready stays low while the tree is built with a
//   dense prim pass: for each of n-1 added points one sweep over all n points
//   (framed by fetch and drain, with the point and distance rams read once
//   per cycle) and one fixed point root. a set of one point answers zero
//   in the cycle after its beat.
//   master side: one beat per set, tdata = total length (unsigned, FRAC_BITS
//   fraction bits, saturating), tuser = overflow flag. the result is held
//   while m_tready is low; no new point is taken until it is delivered.
//   reset empties the point store and drops any pending result.
// ----------------------------------------------------------------------------
module euclidean_mst_length_unit
  import mstl_pkg::*;
#(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,   // x_coord, y_coord
  input  logic                                   s_tlast,   // last_point
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [OUT_TDATA_W-1:0]                 m_tdata,   // total_length
  output logic                                   m_tuser    // too_many_points
);

  localparam int C  = COORD_BITS;
  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = 2 * C + 1;              // squared distance width
  localparam int RW = (DW + 1) / 2 + FRAC_BITS;
  localparam logic [SUM_BITS:0] SUM_MAX = {1'b0, {SUM_BITS{1'b1}}};

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_LATCH = 7'b0000100,
    S_SWEEP = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_ROOT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [CW-1:0] cnt;          // points stored
  logic          ovf;
  logic [CW-1:0] n_pts;
  logic [CW-1:0] added;        // points joined after the first
  logic [IW-1:0] cur;          // point joined last
  logic signed [C-1:0] cx, cy;
  logic [MAX_POINTS-1:0] in_tree;
  logic          first;        // distance ram not yet written in this set

  // sweep pipeline
  logic [CW-1:0] j;
  logic          v1, v2;
  logic [IW-1:0] j1, j2;
  logic [2*C-1:0] sqx, sqy;
  logic [DW-1:0]  dist2;
  logic [DW-1:0]  best;
  logic           best_ok;
  logic [IW-1:0]  bestj;
  logic [SUM_BITS-1:0] sum;

  // point ram: {y, x}
  logic          pt_we;
  logic [IW-1:0] pt_raddr;
  logic [2*C-1:0] pt_rdata;
  logic [DW-1:0]  dist_rdata;
  logic           dist_we;
  logic [DW-1:0]  dist_wdata;

  logic accept;
  logic [CW-1:0] n_eff;

  assign s_tready = (state == S_LOAD);
  assign accept   = s_tvalid && s_tready;
  assign pt_we    = accept && (cnt < CW'(MAX_POINTS));
  assign n_eff    = pt_we ? cnt + CW'(1) : cnt;
  assign pt_raddr = (state == S_FETCH) ? cur : j[IW-1:0];

  mstl_ram #(.WIDTH(2 * C), .DEPTH(MAX_POINTS)) u_points (
    .clk   (clk),
    .we    (pt_we),
    .waddr (cnt[IW-1:0]),
    .wdata (s_tdata[2*C-1:0]),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  mstl_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_dist (
    .clk   (clk),
    .we    (dist_we),
    .waddr (j2),
    .wdata (dist_wdata),
    .raddr (j[IW-1:0]),
    .rdata (dist_rdata)
  );

  // stage one: coordinate differences squared
  logic signed [C:0]     dx, dy;
  logic signed [2*C+1:0] mx, my;
  assign dx = {cx[C-1], cx} - {pt_rdata[C-1], pt_rdata[C-1:0]};
  assign dy = {cy[C-1], cy} - {pt_rdata[2*C-1], pt_rdata[2*C-1:C]};
  assign mx = dx * dx;
  assign my = dy * dy;

  // stage two: distance to the tree, updated in place
  logic [DW-1:0] dsq, newd;
  logic          live2;
  assign dsq        = {1'b0, sqx} + {1'b0, sqy};
  assign newd       = (first || dsq < dist2) ? dsq : dist2;
  assign live2      = v2 && !in_tree[j2];
  assign dist_we    = live2;
  assign dist_wdata = newd;

  // root unit for each chosen edge
  logic            sq_start;
  logic [RW-1:0]   root;
  mstl_sqrt_stat_t sq_stat;
  logic [SUM_BITS:0] sum_add;

  assign sq_start = (state == S_DRAIN) && !v1 && !v2;
  assign sum_add  = {1'b0, sum} + (SUM_BITS + 1)'(root);

  mstl_sqrt #(.IN_W(DW), .FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (best),
    .root  (root),
    .stat  (sq_stat)
  );

  assign m_tdata = {{(OUT_TDATA_W-SUM_BITS){1'b0}}, sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      cnt      <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
    end else begin
      // pipeline moves every cycle
      v1  <= (state == S_SWEEP) && (j < n_pts);
      j1  <= j[IW-1:0];
      v2  <= v1;
      j2  <= j1;
      sqx <= mx[2*C-1:0];
      sqy <= my[2*C-1:0];
      dist2 <= dist_rdata;
      if (live2 && (!best_ok || newd < best)) begin
        best    <= newd;
        bestj   <= j2;
        best_ok <= 1'b1;
      end

      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (pt_we) begin
              cnt <= cnt + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (s_tlast) begin
              n_pts   <= n_eff;
              sum     <= '0;
              cur     <= '0;
              in_tree <= MAX_POINTS'(1);
              added   <= '0;
              first   <= 1'b1;
              best_ok <= 1'b0;
              if (n_eff <= CW'(1)) begin
                m_tvalid <= 1'b1;
                m_tuser  <= ovf || !pt_we;
                state    <= S_OUT;
              end else begin
                state <= S_FETCH;
              end
            end
          end
        end
        S_FETCH: begin
          state <= S_LATCH;
        end
        S_LATCH: begin
          cx    <= pt_rdata[C-1:0];
          cy    <= pt_rdata[2*C-1:C];
          j     <= '0;
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          // issue one point per cycle, then let the pipeline empty
          if (j < n_pts) begin
            j <= j + CW'(1);
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (sq_start) begin
            in_tree[bestj] <= 1'b1;
            cur            <= bestj;
            added          <= added + CW'(1);
            first          <= 1'b0;
            state          <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sq_stat.done) begin
            sum     <= (sum_add > SUM_MAX) ? SUM_MAX[SUM_BITS-1:0] : sum_add[SUM_BITS-1:0];
            best_ok <= 1'b0;
            if (added == n_pts - CW'(1)) begin
              m_tvalid <= 1'b1;
              m_tuser  <= ovf;
              state    <= S_OUT;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            cnt      <= '0;
            ovf      <= 1'b0;
            state    <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule
